FILE: sv/swdm_pkg.sv
`timescale 1ns / 1ps

package swdm_pkg;

    localparam int DEFAULT_DEPTH = 128;
    localparam int WORD_W        = 32;
    localparam int COUNT_OUT_W   = 8;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_DELMID = 2'd2
    } t_cmd;

    // per-cycle shift controls broadcast to every cell
    typedef struct packed {
        logic push;  // every cell takes its upper neighbor
        logic pop;   // every cell takes its lower neighbor
        logic del;   // cells at or below the split point take their lower neighbor
    } t_cell_ctl;

endpackage

FILE: sv/swdm_cell.sv
`timescale 1ns / 1ps

module swdm_cell #(
    parameter int DEPTH = 128,
    parameter int IDX   = 0
) (
    input  logic                     i_clk,
    input  swdm_pkg::t_cell_ctl      i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_del_from,
    input  swdm_pkg::t_word          i_up,
    input  swdm_pkg::t_word          i_dn,
    output swdm_pkg::t_word          o_q
);
    import swdm_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    t_word r_q;
    t_word n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.push) begin
            n_q = i_up;
        end else if (i_ctl.pop) begin
            n_q = i_dn;
        end else if (i_ctl.del && (MY_IDX >= i_del_from)) begin
            n_q = i_dn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

FILE: sv/stack_with_delete_middle.sv
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_command, i_push_value
// result    out        o_out_valid / i_out_stall o_pop_value, o_empty_flag,
//                                                o_full_flag, o_entry_count
//
// one item per cycle while the result side does not stall: every command finishes in the cycle it is accepted,
// since all cells of the chain shift in parallel
// the result is registered and shows in the cycle after the item is accepted
// reset clears the count and the result valid; cell contents are left as is
// input stalls only while a result waits and the result side stalls

module stack_with_delete_middle #(
    parameter int DEPTH = swdm_pkg::DEFAULT_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_command,
    input  swdm_pkg::t_word                       i_push_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output swdm_pkg::t_word                       o_pop_value,
    output logic                                  o_empty_flag,
    output logic                                  o_full_flag,
    output logic [swdm_pkg::COUNT_OUT_W-1:0]      o_entry_count
);
    import swdm_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // the chain keeps the top of the stack in cell 0, deeper entries further on
    t_word cell_q [DEPTH];

    logic              accept;
    logic              is_empty;
    logic              is_full;
    t_cell_ctl         ctl;
    logic [IW-1:0]     del_from;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    t_word             r_pop_value;
    logic              r_empty_flag;
    logic              r_full_flag;
    logic [COUNT_OUT_W-1:0] r_entry_count;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count == FULL_COUNT);

    // delete middle: with n entries the removed one sits n/2 places below the top,
    // so that cell and everything deeper moves one place toward the top
    assign del_from = IW'(r_count >> 1);

    always_comb begin
        ctl      = '0;
        n_count  = r_count;
        if (accept) begin
            case (i_command)
                CMD_PUSH: begin
                    if (!is_full) begin
                        ctl.push = 1'b1;
                        n_count  = r_count + CW'(1);
                    end
                end
                CMD_POP: begin
                    if (!is_empty) begin
                        ctl.pop = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end
                CMD_DELMID: begin
                    if (!is_empty) begin
                        ctl.del = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_word up_w;
            t_word dn_w;
            if (gi == 0) begin : g_top
                assign up_w = i_push_value;
            end else begin : g_mid
                assign up_w = cell_q[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                // nothing lies below the deepest cell; it only ever shifts out garbage
                assign dn_w = cell_q[gi];
            end else begin : g_inner
                assign dn_w = cell_q[gi+1];
            end
            swdm_cell #(
                .DEPTH (DEPTH),
                .IDX   (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_del_from (del_from),
                .i_up       (up_w),
                .i_dn       (dn_w),
                .o_q        (cell_q[gi])
            );
        end
    endgenerate

    // count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with the item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pop_value   <= '0;
            r_empty_flag  <= 1'b0;
            r_full_flag   <= 1'b0;
            r_entry_count <= COUNT_OUT_W'(n_count);
            case (i_command)
                CMD_PUSH: begin
                    r_full_flag <= is_full;
                end
                CMD_POP: begin
                    r_pop_value  <= is_empty ? t_word'(-1) : cell_q[0];
                    r_empty_flag <= is_empty;
                end
                CMD_DELMID: begin
                    r_empty_flag <= is_empty;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pop_value   = r_pop_value;
    assign o_empty_flag  = r_empty_flag;
    assign o_full_flag   = r_full_flag;
    assign o_entry_count = r_entry_count;

    // count never runs past the chain length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("count beyond depth");

    // a pending result reports the count the stack holds
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_entry_count == COUNT_OUT_W'(r_count)))
        else $error("reported count differs from stack count");

    // a dropped push is only reported on a full stack
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_full_flag) |-> is_full)
        else $error("full flag on a stack that is not full");

    // a pop on a non-empty stack takes exactly one entry away
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_command == CMD_POP) && !is_empty)
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not remove one entry");

endmodule

FILE: verif/tb_stack_with_delete_middle.sv
`timescale 1ns / 1ps

// one result as the block reports it
typedef struct {
    swdm_pkg::t_word pop_value;
    logic            empty;
    logic            full;
    logic [7:0]      count;
} t_stack_result;

// shadow copy of the stack plus the results still owed by the block
class stack_tracker;
    swdm_pkg::t_word cells[swdm_pkg::DEFAULT_DEPTH];
    int              depth_used;
    t_stack_result   awaited_results[$];
    int              error_count;

    function new();
        depth_used  = 0;
        error_count = 0;
    endfunction

    // apply one accepted command to the shadow stack and queue its result
    function void apply_command(logic [1:0] cmd, swdm_pkg::t_word word);
        t_stack_result r;
        int            mid;
        r.pop_value = '0;
        r.empty     = 1'b0;
        r.full      = 1'b0;
        case (cmd)
            swdm_pkg::CMD_PUSH: begin
                if (depth_used < swdm_pkg::DEFAULT_DEPTH) begin
                    cells[depth_used] = word;
                    depth_used++;
                end else begin
                    r.full = 1'b1;
                end
            end
            swdm_pkg::CMD_POP: begin
                if (depth_used > 0) begin
                    depth_used--;
                    r.pop_value = cells[depth_used];
                end else begin
                    r.pop_value = -1;
                    r.empty     = 1'b1;
                end
            end
            swdm_pkg::CMD_DELMID: begin
                if (depth_used > 0) begin
                    mid = (depth_used + 1) / 2 - 1;
                    for (int i = mid; i + 1 < depth_used; i++) begin
                        cells[i] = cells[i + 1];
                    end
                    depth_used--;
                end else begin
                    r.empty = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = depth_used[7:0];
        awaited_results.push_back(r);
    endfunction

    // compare one accepted result with the oldest one owed
    function void check_result(swdm_pkg::t_word pop_value, logic empty, logic full,
                               logic [7:0] count);
        t_stack_result e;
        if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got pop %0d empty %0b full %0b count %0d",
                     $time, pop_value, empty, full, count);
            error_count++;
            return;
        end
        e = awaited_results.pop_front();
        if (pop_value !== e.pop_value) begin
            $display("%0t: pop_value expected %0d got %0d", $time, e.pop_value, pop_value);
            error_count++;
        end
        if (empty !== e.empty) begin
            $display("%0t: empty_flag expected %0b got %0b", $time, e.empty, empty);
            error_count++;
        end
        if (full !== e.full) begin
            $display("%0t: full_flag expected %0b got %0b", $time, e.full, full);
            error_count++;
        end
        if (count !== e.count) begin
            $display("%0t: entry_count expected %0d got %0d", $time, e.count, count);
            error_count++;
        end
    endfunction
endclass

module tb_stack_with_delete_middle;

    localparam int         STACK_DEPTH  = swdm_pkg::DEFAULT_DEPTH;
    // code 3 is not decoded by the block and must act as a no-op
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1550;
    localparam int         CYCLE_LIMIT  = 800000;
    localparam int         SETTLE_WAIT  = 8;

    // kinds of random bursts: fill to full, drain to empty, or a free mix
    typedef enum { BURST_FILL, BURST_DRAIN, BURST_MIX } t_burst;

    logic            i_clk        = 1'b0;
    logic            i_rst_n      = 1'b0;
    logic            i_in_valid   = 1'b0;
    logic            o_in_stall;
    logic [1:0]      i_command    = 2'd0;
    swdm_pkg::t_word i_push_value = '0;
    logic            o_out_valid;
    logic            i_out_stall  = 1'b0;
    swdm_pkg::t_word o_pop_value;
    logic            o_empty_flag;
    logic            o_full_flag;
    logic [7:0]      o_entry_count;

    stack_tracker tracker = new();
    int           items_sent  = 0;
    int           cycle_count = 0;
    // when set, neither side idles: back-to-back traffic
    bit           steady      = 1'b0;

    stack_with_delete_middle #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pop_value  (o_pop_value),
        .o_empty_flag (o_empty_flag),
        .o_full_flag  (o_full_flag),
        .o_entry_count(o_entry_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop in case the handshake hangs
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // push data: mostly random words, sometimes the corner values
    function automatic swdm_pkg::t_word next_word();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // command mix per burst kind
    function automatic logic [1:0] pick_command(t_burst kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            BURST_FILL: begin
                if (r < 85) return swdm_pkg::CMD_PUSH;
                if (r < 95) return swdm_pkg::CMD_DELMID;
                return swdm_pkg::CMD_POP;
            end
            BURST_DRAIN: begin
                if (r < 50) return swdm_pkg::CMD_POP;
                if (r < 95) return swdm_pkg::CMD_DELMID;
                return CMD_UNUSED;
            end
            default: begin
                if (r < 35) return swdm_pkg::CMD_PUSH;
                if (r < 60) return swdm_pkg::CMD_POP;
                if (r < 90) return swdm_pkg::CMD_DELMID;
                return CMD_UNUSED;
            end
        endcase
    endfunction

    // offer one item; called at a rising edge, returns at the edge it is taken
    task automatic send_item(input logic [1:0] cmd, input swdm_pkg::t_word word);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_push_value <= word;
        // decide acceptance mid-cycle, where every signal is settled
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        tracker.apply_command(cmd, word);
        items_sent++;
    endtask

    task automatic run_burst(input t_burst kind);
        int extra;
        int len;
        // about one burst in five runs without any idling
        steady = ($urandom_range(0, 4) == 0);
        case (kind)
            BURST_FILL: begin
                while (tracker.depth_used < STACK_DEPTH) begin
                    send_item(pick_command(kind), next_word());
                end
                // a few pushes against a full stack
                extra = $urandom_range(1, 4);
                repeat (extra) send_item(swdm_pkg::CMD_PUSH, next_word());
            end
            BURST_DRAIN: begin
                while (tracker.depth_used > 0) begin
                    send_item(pick_command(kind), next_word());
                end
                // pops, deletes and now and then the unused code against an empty stack
                extra = $urandom_range(1, 3);
                repeat (extra) send_item(pick_command(kind), next_word());
            end
            default: begin
                len = $urandom_range(20, 80);
                repeat (len) send_item(pick_command(kind), next_word());
            end
        endcase
    endtask

    // result side stall: random runs of stall and no stall
    initial begin
        int hold;
        @(posedge i_clk);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // results are taken at the next rising edge; compare the settled values
    initial begin
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                tracker.check_result(o_pop_value, o_empty_flag, o_full_flag, o_entry_count);
            end
        end
    end

    initial begin
        int     random_start;
        int     r;
        t_burst kind;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // commands on an empty stack
        send_item(swdm_pkg::CMD_POP, '0);
        send_item(swdm_pkg::CMD_DELMID, '0);
        send_item(CMD_UNUSED, 32'hdead_beef);
        // delete-middle on a single entry
        send_item(swdm_pkg::CMD_PUSH, 32'h8000_0000);
        send_item(swdm_pkg::CMD_DELMID, '0);
        // four entries, then delete-middle at sizes four, three and two
        send_item(swdm_pkg::CMD_PUSH, 32'h7fff_ffff);
        send_item(swdm_pkg::CMD_PUSH, 32'hffff_ffff);
        send_item(swdm_pkg::CMD_PUSH, 32'h0000_0000);
        send_item(swdm_pkg::CMD_PUSH, 32'h0000_0001);
        send_item(swdm_pkg::CMD_DELMID, 32'hffff_ffff);
        send_item(swdm_pkg::CMD_DELMID, '0);
        send_item(CMD_UNUSED, '0);
        send_item(swdm_pkg::CMD_PUSH, 32'haaaa_aaaa);
        send_item(swdm_pkg::CMD_PUSH, 32'h5555_5555);
        send_item(swdm_pkg::CMD_POP, '0);
        send_item(swdm_pkg::CMD_DELMID, '0);
        send_item(swdm_pkg::CMD_DELMID, '0);
        send_item(swdm_pkg::CMD_POP, 32'h1234_5678);
        send_item(swdm_pkg::CMD_POP, '0);

        // random part starts with a fill so push-when-full is always hit
        random_start = items_sent;
        run_burst(BURST_FILL);
        while (items_sent - random_start < RANDOM_ITEMS) begin
            r = $urandom_range(0, 3);
            kind = (r == 0) ? BURST_FILL : (r == 1) ? BURST_DRAIN : BURST_MIX;
            run_burst(kind);
        end
        i_in_valid <= 1'b0;
        steady = 1'b0;

        // wait for every owed result, then a little longer for strays
        while (tracker.awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        if (tracker.error_count == 0 && tracker.awaited_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
